>>> hw/rtl/b64e_pkg.sv
package b64e_pkg;

  // Depth of the group queue between the byte collector and the serializer.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned GROUP_W  = 24;

  localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'd61;  // '='
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'd43;  // '+'
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'd47;  // '/'

  // One group of up to three bytes, with the number of padding characters
  // that replace its trailing sextets, and the end-of-message flag.
  typedef struct packed {
    logic [GROUP_W-1:0] bits;
    logic [1:0]         pads;
    logic               fin;
  } grp_t;

  // Standard alphabet lookup.
  function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXTET_W-1:0] v);
    logic [CHAR_W-1:0] w;
    w = {1'b0, v};
    if (v < 6'd26) begin
      b64_char = w + 7'd65;
    end else if (v < 6'd52) begin
      b64_char = w + 7'd71;
    end else if (v < 6'd62) begin
      b64_char = w - 7'd4;
    end else if (v == 6'd62) begin
      b64_char = PLUS_CHAR;
    end else begin
      b64_char = SLASH_CHAR;
    end
  endfunction

endpackage

>>> hw/rtl/b64e_front.sv
module b64e_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               final_byte_i,
  output logic               grp_push_o,
  output b64e_pkg::grp_t     grp_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;

  always_comb begin
    held_d     = held_q;
    cnt_d      = cnt_q;
    grp_push_o = 1'b0;
    grp_o      = '0;
    if (accept_i) begin
      if (cnt_q[1]) begin
        // Two bytes held: this byte completes a full group.
        grp_push_o = 1'b1;
        grp_o.bits = {held_q, in_byte_i};
        grp_o.pads = 2'd0;
        grp_o.fin  = final_byte_i;
        held_d     = '0;
        cnt_d      = '0;
      end else if (!final_byte_i) begin
        held_d = {held_q[7:0], in_byte_i};
        cnt_d  = cnt_q + 2'd1;
      end else begin
        // Last byte of a partial group: flush with padding.
        grp_push_o = 1'b1;
        grp_o.fin  = 1'b1;
        if (cnt_q == 2'd0) begin
          grp_o.bits = {in_byte_i, 16'h0000};
          grp_o.pads = 2'd2;
        end else begin
          grp_o.bits = {held_q[7:0], in_byte_i, 8'h00};
          grp_o.pads = 2'd1;
        end
        held_d = '0;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_below_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("byte collector holds more than two bytes");
`endif

endmodule

>>> hw/rtl/b64e_fifo.sv
module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64e_pkg::grp_t  data_i,
  input  logic            pop_i,
  output b64e_pkg::grp_t  data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::grp_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("group pushed into a full queue");
  a_pointers_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with an empty count");
`endif

endmodule

>>> hw/rtl/b64e_back.sv
module b64e_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            grp_valid_i,
  input  b64e_pkg::grp_t  grp_i,
  output logic            grp_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [6:0]      out_char_o,
  output logic            run_last_o,
  output logic            message_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d, end_q, end_d;
  logic       taken, load;
  logic [5:0] sextet;
  logic [2:0] pad_sum;

  assign taken = pop_i && out_valid_q;
  assign load  = grp_valid_i && (!out_valid_q || taken);

  always_comb begin
    case (idx_q)
      2'd0:    sextet = grp_i.bits[23:18];
      2'd1:    sextet = grp_i.bits[17:12];
      2'd2:    sextet = grp_i.bits[11:6];
      default: sextet = grp_i.bits[5:0];
    endcase
  end

  // The last pads characters of a group are padding.
  assign pad_sum = {1'b0, idx_q} + {1'b0, grp_i.pads};

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    end_d       = end_q;
    grp_pop_o   = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      char_d      = pad_sum[2] ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(sextet);
      last_d      = (idx_q == 2'd3);
      end_d       = (idx_q == 2'd3) && grp_i.fin;
      idx_d       = idx_q + 2'd1;
      grp_pop_o   = (idx_q == 2'd3);
    end else if (taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    end_q  <= end_d;
  end

  assign empty_o       = !out_valid_q;
  assign out_char_o    = char_q;
  assign run_last_o    = last_q;
  assign message_end_o = end_q;

`ifndef SYNTHESIS
  a_mid_group_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> grp_valid_i)
    else $error("serializer is inside a group but the queue is empty");
  a_end_marks_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && end_q) |-> last_q)
    else $error("message end without end of run");
`endif

endmodule

>>> hw/rtl/base64_stream_encoder.sv
// Path: a byte that completes a group (or ends a message) is written into the
// group queue at the edge that accepts it; the serializer then registers its first character.
// Throughput: one character per cycle while pop is held high; every group of up
// to three bytes gives four characters, so the serializer, not the byte side,
// sets the sustained rate.
// Reset: rst_ni is asynchronous and active low; it empties the queue and drops held bytes.
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Byte requests, queue style.
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  // Character results, queue style.
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       run_last_o,
  output logic       message_end_o
);

  // The front collects bytes into groups of three. Whenever a group is
  // complete, or a final byte closes a partial one, it pushes the group with
  // its padding count into a short queue. The back turns each queued group
  // into four characters through an output register, so a waiting character
  // never blocks the front from taking more bytes while the queue has room.
  b64e_pkg::grp_t grp_in, grp_head;
  logic           grp_push, grp_pop, q_full, q_empty, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .grp_push_o   (grp_push),
    .grp_o        (grp_in)
  );

  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .pop_i   (grp_pop),
    .data_o  (grp_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grp_valid_i   (!q_empty),
    .grp_i         (grp_head),
    .grp_pop_o     (grp_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

>>> tb/base64_stream_encoder_tb.sv
`timescale 1ns / 100ps

module base64_stream_encoder_tb;

  // Standard alphabet, one ASCII byte per sextet value, 'A' in the top byte.
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Directed messages, back to back. A set bit in DIR_LAST marks the byte
  // that closes a message.
  localparam int DIR_N = 24;
  localparam logic [7:0] DIR_BYTES [DIR_N] = '{
    8'h00,                          // one byte of zeros: two pads
    8'hFF,                          // one byte of ones: two pads
    8'h00, 8'hFF,                   // two bytes: one pad
    8'hFF, 8'h00,                   // two bytes, reversed
    8'hFF, 8'hFF, 8'hFF,            // full group ending the message, all '/'
    8'hFB, 8'hEF, 8'hBE,            // full group ending the message, all '+'
    8'h00, 8'h00, 8'h00, 8'h80, 8'h01,               // group, then two-byte tail
    8'h4D, 8'h61, 8'h6E, 8'h01, 8'h02, 8'h03, 8'hAA  // two groups, one-byte tail
  };
  localparam logic [DIR_N-1:0] DIR_LAST =
    (24'd1 << 0) | (24'd1 << 1) | (24'd1 << 3) | (24'd1 << 5) | (24'd1 << 8) |
    (24'd1 << 11) | (24'd1 << 16) | (24'd1 << 23);

  // One expected character with its two flags.
  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       msg_end;
  } char_rec_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       final_byte_i;
  logic       empty;
  logic       pop;
  logic [6:0] out_char_o;
  logic       run_last_o;
  logic       message_end_o;

  // Characters that the accepted bytes must still produce, oldest first.
  char_rec_t pending_chars[$];
  int        err_cnt = 0;

  // Encoder state as the checker sees it: the bytes of an unfinished group,
  // oldest in the upper half, and how many of them there are.
  logic [15:0] held_bytes = '0;
  logic [1:0]  held_cnt   = '0;

  // Traffic shaping. When calm is set neither side idles. hold_cycles asks
  // the result side to hold pop low until it has counted down to zero.
  bit calm      = 0;
  bit rx_bursty = 1;
  int hold_cycles = 0;

  base64_stream_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .final_byte_i  (final_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [6:0] sextet_ascii(input logic [5:0] s);
    return ALPHABET[8*(63 - int'(s)) +: 7];
  endfunction

  function automatic void add_char(input logic [6:0] ch, input logic last,
                                   input logic msg_end);
    char_rec_t r;
    r.ch       = ch;
    r.run_last = last;
    r.msg_end  = msg_end;
    pending_chars = {pending_chars, r};
  endfunction

  // Advances the expected encoder state by one accepted byte and queues the
  // characters it causes. A held count of three cannot arise, but it would
  // be handled like two, as the group-complete branch does.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [23:0] grp;
    if (held_cnt >= 2'd2) begin
      // The byte completes a group of three: four characters, no padding.
      grp = {held_bytes, b};
      add_char(sextet_ascii(grp[23:18]), 1'b0, 1'b0);
      add_char(sextet_ascii(grp[17:12]), 1'b0, 1'b0);
      add_char(sextet_ascii(grp[11:6]), 1'b0, 1'b0);
      add_char(sextet_ascii(grp[5:0]), 1'b1, fin);
      held_bytes = '0;
      held_cnt   = '0;
    end else if (!fin) begin
      // Group still incomplete: hold the byte, nothing comes out.
      held_bytes = {held_bytes[7:0], b};
      held_cnt   = held_cnt + 2'd1;
    end else if (held_cnt == 2'd0) begin
      // Lone final byte: two characters and two pads.
      grp = {b, 16'h0000};
      add_char(sextet_ascii(grp[23:18]), 1'b0, 1'b0);
      add_char(sextet_ascii(grp[17:12]), 1'b0, 1'b0);
      add_char(b64e_pkg::PAD_CHAR, 1'b0, 1'b0);
      add_char(b64e_pkg::PAD_CHAR, 1'b1, 1'b1);
      held_bytes = '0;
      held_cnt   = '0;
    end else begin
      // Two-byte tail: three characters and one pad. Only the newest held
      // byte belongs to this message's tail.
      grp = {held_bytes[7:0], b, 8'h00};
      add_char(sextet_ascii(grp[23:18]), 1'b0, 1'b0);
      add_char(sextet_ascii(grp[17:12]), 1'b0, 1'b0);
      add_char(sextet_ascii(grp[11:6]), 1'b0, 1'b0);
      add_char(b64e_pkg::PAD_CHAR, 1'b1, 1'b1);
      held_bytes = '0;
      held_cnt   = '0;
    end
  endfunction

  // Offers one byte request and returns once the encoder has taken it. When
  // idling is allowed, push may first drop for a random burst of cycles.
  // Push is only ever changed once per falling edge, so back-to-back requests
  // keep it high without a glitch.
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && !calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push         <= 1'b1;
    in_byte_i    <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (full);
    encode_byte(b, fin);
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // The result side: pops at random, with idle bursts of random length,
  // stretches with no idling at all, and long hold-offs on request.
  initial begin
    int stall;
    int stretch;
    stall   = 0;
    stretch = 0;
    pop     = 1'b0;
    forever begin
      @(negedge clk_i);
      stretch++;
      if (stretch == 50) begin
        stretch   = 0;
        rx_bursty = $urandom_range(0, 2) != 0;
      end
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!calm && rx_bursty && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 15);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Every accepted character is matched against the oldest expectation.
  always @(posedge clk_i) begin
    char_rec_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got char %0d last %0b end %0b",
                 $time, out_char_o, run_last_o, message_end_o);
        err_cnt++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch) begin
          $display("%0t: out_char mismatch: expected %0d, got %0d",
                   $time, want.ch, out_char_o);
          err_cnt++;
        end
        if (run_last_o !== want.run_last) begin
          $display("%0t: run_last mismatch: expected %0b, got %0b",
                   $time, want.run_last, run_last_o);
          err_cnt++;
        end
        if (message_end_o !== want.msg_end) begin
          $display("%0t: message_end mismatch: expected %0b, got %0b",
                   $time, want.msg_end, message_end_o);
          err_cnt++;
        end
      end
    end
  end

  // Hand-picked messages: all-zero and all-one bytes, both pad counts,
  // complete groups that close a message, and groups that do not.
  task automatic test_directed();
    for (int i = 0; i < DIR_N; i++) begin
      send_byte(DIR_BYTES[i], DIR_LAST[i], 1'b1);
    end
  endtask

  // Random messages of mostly short length, so that every tail case comes
  // up often, with a few long ones that run through many full groups.
  task automatic test_random_messages(input int n_bytes);
    int sent;
    int len;
    bit bursty;
    sent = 0;
    while (sent < n_bytes) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      bursty = $urandom_range(0, 2) != 0;
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == len - 1, bursty);
      end
      sent += len;
    end
  endtask

  // The result side stops popping for a long while and the byte side keeps
  // offering requests, so the group queue fills and full must hold them off.
  task automatic test_backpressure();
    hold_cycles = 80;
    for (int i = 0; i < 36; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 35, 1'b0);
    end
    // Withdraw the last request so that it is not taken a second time.
    @(negedge clk_i);
    push <= 1'b0;
    wait_drained();
  endtask

  // Closing stretch with neither side idling, to run at the full rate.
  task automatic test_full_rate();
    calm = 1;
    test_random_messages(40);
  endtask

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    in_byte_i    = '0;
    final_byte_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_messages(130);
    test_backpressure();
    test_full_rate();

    @(negedge clk_i);
    push <= 1'b0;
    wait_drained();
    // A few more edges so that a stray extra character would still be seen.
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of a few hundred bytes.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
tb/base64_stream_encoder_tb.sv
